FILE: rtl/bfmc_pkg.sv
// Package for the mip chain generator: shared types and constants.
// No dependencies.
package bfmc_pkg;
    localparam int NCH = 4;

    typedef struct packed {
        logic [3:0] level;
        logic [8:0] out_x;
        logic [8:0] out_y;
        logic [7:0] res_0;
        logic [7:0] res_1;
        logic [7:0] res_2;
        logic [7:0] res_3;
        logic       last_of_run;
        logic       chain_done;
    } result_t;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
endpackage

FILE: rtl/box_filter_mip_chain.sv
// Top level of the mip chain generator: sequencer, per-level counters,
// pair-sum memory and output register. Depends on bfmc_pkg.
//
// Flow: one input texel holds the block while the results it causes are made
// (read, combine, hand-off per level) and while a pending result waits on
// m_axis_tready; s_axis_tready is low meanwhile, so no new texel is taken before
// the last one is through. A result leaves res_reg for the output register once
// the next level has been evaluated, in RD when the chain ends there, else in CMB.
// Reset (aresetn, synchronous, low): sizes return to 1024x1024, counters and
// held texels clear; the pair-sum memory is not cleared (always written on an
// even row before the odd row reads it).
module box_filter_mip_chain #(
    parameter int MAX_DIM    = 1024,
    parameter int MAX_LEVELS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // chan_0, chan_1, chan_2, chan_3
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,  // level, out_x, out_y, res_0..res_3, zero pad
    output logic        m_axis_tlast,  // last_of_run
    output logic [0:0]  m_axis_tuser,  // chain_done
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [10:0] cfg_wdata
);
    import bfmc_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int AW = $clog2(MAX_DIM);
    localparam int LW = $clog2(MAX_LEVELS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RD   = 4'b0010,
        ST_CMB  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg;
    logic [10:0] bw_reg, bh_reg;
    logic [DW-1:0] w_reg, h_reg;       // dims of current source level
    logic [LW-1:0] s_reg;
    logic [AW:0]   off_reg;
    logic [7:0]    tex_reg [NCH];
    logic [7:0]    held_reg [MAX_LEVELS][NCH];
    logic [DW-1:0] col_reg [MAX_LEVELS];
    logic [DW-1:0] row_reg [MAX_LEVELS];
    logic [35:0]   mem [MAX_DIM];
    logic [35:0]   rd_reg;
    result_t       res_reg;
    logic          ov_reg;              // output register full
    logic          pend_reg;            // res_reg waits for the next level
    result_t       obuf_reg;

    // pending result can only move out when the output register frees up
    logic obuf_free, hold;
    assign obuf_free = !ov_reg || m_axis_tready;
    assign hold      = pend_reg && !obuf_free;

    // effective base dims
    logic [DW-1:0] ew, eh;
    always_comb begin
        ew = (bw_reg == 11'd0) ? DW'(1) :
             ({21'd0, bw_reg} > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(bw_reg);
        eh = (bh_reg == 11'd0) ? DW'(1) :
             ({21'd0, bh_reg} > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(bh_reg);
    end

    logic [DW-1:0] dw, dh, c, r;
    logic [AW:0]   x, idx;
    logic [8:0]    pair [NCH];
    logic [9:0]    sum [NCH];
    logic          odd_c_ok, do_out;
    always_comb begin
        dw = (w_reg > DW'(1)) ? (w_reg >> 1) : DW'(1);
        dh = (h_reg > DW'(1)) ? (h_reg >> 1) : DW'(1);
        c  = col_reg[s_reg[LW-1:0] < LW'(MAX_LEVELS) ? s_reg : '0];
        r  = row_reg[s_reg[LW-1:0] < LW'(MAX_LEVELS) ? s_reg : '0];
        x  = (w_reg == DW'(1)) ? '0 : (AW+1)'(c >> 1);
        idx = off_reg + x;
        odd_c_ok = (w_reg == DW'(1)) || c[0];
        for (int k = 0; k < NCH; k++) begin
            pair[k] = (w_reg == DW'(1)) ? {tex_reg[k], 1'b0}
                : 9'(held_reg[s_reg][k]) + 9'(tex_reg[k]);
            sum[k] = (h_reg == DW'(1)) ? {pair[k], 1'b0}
                : 10'(rd_reg[k*9 +: 9]) + 10'(pair[k]);
        end
        do_out = odd_c_ok && ({1'b0, x} < {1'b0, (AW+1)'(dw)}) &&
                 (idx < (AW+1)'(MAX_DIM)) && ((h_reg == DW'(1)) || r[0]);
    end

    logic chain_on;
    assign chain_on = (w_reg > DW'(1) || h_reg > DW'(1)) &&
                      (s_reg < LW'(MAX_LEVELS));

    assign s_axis_tready = (state_reg == ST_IDLE) && aresetn;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_RD)
            rd_reg <= mem[idx[AW-1:0]];
        if (state_reg == ST_CMB && !hold && odd_c_ok && x < (AW+1)'(dw) &&
            idx < (AW+1)'(MAX_DIM) && h_reg != DW'(1) && !r[0])
            mem[idx[AW-1:0]] <= {pair[3], pair[2], pair[1], pair[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bw_reg <= 11'd1024;
            bh_reg <= 11'd1024;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
                for (int k = 0; k < NCH; k++) held_reg[i][k] <= '0;
            end
        end else begin
            if (cfg_we) begin
                if (cfg_addr == CFG_WIDTH) bw_reg <= cfg_wdata;
                else bh_reg <= cfg_wdata;
                for (int i = 0; i < MAX_LEVELS; i++) begin
                    col_reg[i] <= '0;
                    row_reg[i] <= '0;
                    for (int k = 0; k < NCH; k++) held_reg[i][k] <= '0;
                end
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        for (int k = 0; k < NCH; k++)
                            tex_reg[k] <= s_axis_tdata[k*8 +: 8];
                        w_reg <= ew;
                        h_reg <= eh;
                        s_reg <= '0;
                        off_reg <= '0;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    if (!hold)
                        state_reg <= chain_on ? ST_CMB : ST_IDLE;
                end
                ST_CMB: begin
                    if (!hold) begin
                        if (c + DW'(1) >= w_reg) begin
                            col_reg[s_reg] <= '0;
                            row_reg[s_reg] <= (r + DW'(1) >= h_reg) ? '0 : r + DW'(1);
                        end else begin
                            col_reg[s_reg] <= c + DW'(1);
                        end
                        if (w_reg != DW'(1) && !c[0])
                            for (int k = 0; k < NCH; k++) held_reg[s_reg][k] <= tex_reg[k];
                        if (do_out) begin
                            res_reg.level <= 4'(s_reg + LW'(1));
                            res_reg.out_x <= 9'(x);
                            res_reg.out_y <= (h_reg == DW'(1)) ? 9'd0 : 9'(r >> 1);
                            res_reg.res_0 <= 8'((sum[0] + 10'd2) >> 2);
                            res_reg.res_1 <= 8'((sum[1] + 10'd2) >> 2);
                            res_reg.res_2 <= 8'((sum[2] + 10'd2) >> 2);
                            res_reg.res_3 <= 8'((sum[3] + 10'd2) >> 2);
                            res_reg.chain_done <= (dw == DW'(1)) && (dh == DW'(1));
                            for (int k = 0; k < NCH; k++)
                                tex_reg[k] <= 8'((sum[k] + 10'd2) >> 2);
                            // last unless next level will also emit: decided later
                            res_reg.last_of_run <= 1'b0;
                            off_reg <= off_reg + (AW+1)'(MAX_DIM >> (s_reg + 1));
                            w_reg <= dw;
                            h_reg <= dh;
                            s_reg <= s_reg + LW'(1);
                            state_reg <= ST_OUT;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_OUT: begin
                    // hold result until we know if next level emits too;
                    // evaluate next level by going through RD/CMB first
                    state_reg <= ST_RD;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Pending result: held in res_reg until the following level resolves.
    // Emit when the next stage either produces (last=0) or ends (last=1).
    logic emit_now, emit_last;
    result_t emit_res;
    always_comb begin
        emit_now = 1'b0;
        emit_last = 1'b0;
        if (pend_reg && obuf_free && state_reg == ST_RD && !chain_on) begin
            emit_now = 1'b1; emit_last = 1'b1;
        end else if (pend_reg && obuf_free && state_reg == ST_CMB) begin
            emit_now = 1'b1; emit_last = !do_out;
        end
        emit_res = res_reg;
        emit_res.last_of_run = emit_last;
    end

    // Sequencer waits in RD/CMB (hold) while a pending result has nowhere to go,
    // so the output register is only loaded when empty or draining.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            if (emit_now) begin
                obuf_reg <= emit_res;
                ov_reg <= 1'b1;
                pend_reg <= 1'b0;
            end else if (ov_reg && m_axis_tready) begin
                ov_reg <= 1'b0;
            end
            if (state_reg == ST_OUT) pend_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {2'b0, obuf_reg.res_3, obuf_reg.res_2, obuf_reg.res_1,
                            obuf_reg.res_0, obuf_reg.out_y, obuf_reg.out_x,
                            obuf_reg.level};
    assign m_axis_tlast  = obuf_reg.last_of_run;
    assign m_axis_tuser  = obuf_reg.chain_done;
endmodule

FILE: rtl/bfmc_checker.sv
// Port-level checks for the mip chain generator; bound to the top level.
// Depends on box_filter_mip_chain ports only.
module bfmc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("payload changed while stalled");
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[3:0] != 4'd0)
        else $error("level zero");
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("chain done not last");
    a_noaccept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");
endmodule

bind box_filter_mip_chain bfmc_checker u_bfmc_checker (.*);
